[sv/srtf_pkg.sv]
// shared types and constants for the shortest-remaining-time tick scheduler
package srtf_pkg;

  localparam int MaxProcs = 64;
  localparam int TimeBits = 16;
  localparam int IdxW     = $clog2(MaxProcs);
  localparam int CntW     = $clog2(MaxProcs + 1);
  localparam int IdW      = 8;
  localparam int OutW     = 16;

  localparam logic [TimeBits-1:0] TimeMax = {TimeBits{1'b1}};

  localparam logic [1:0] ReqLoad  = 2'd0;
  localparam logic [1:0] ReqTick  = 2'd1;
  localparam logic [1:0] ReqClear = 2'd2;
  localparam logic [1:0] ReqNop   = 2'd3;

  typedef enum logic [1:0] {
    OP_LOAD,
    OP_TICK,
    OP_CLEAR,
    OP_NOP
  } op_e;

  typedef struct packed {
    op_e                 op;
    logic [IdW-1:0]      id;
    logic [TimeBits-1:0] arr;
    logic [OutW-1:0]     burst;
    logic                burst_nz;
  } req_t;

  typedef struct packed {
    logic            accepted;
    logic            idle;
    logic [IdW-1:0]  run_id;
    logic            switched;
    logic            finished;
    logic [OutW-1:0] turnaround;
    logic [OutW-1:0] waiting;
    logic            all_done;
    logic [OutW-1:0] now;
  } rsp_t;

  function automatic logic [TimeBits-1:0] clamp_time(input logic [OutW-1:0] v);
    logic [31:0] w;
    w = 32'(v);
    clamp_time = (w > 32'(TimeMax)) ? TimeMax : TimeBits'(w);
  endfunction

  function automatic logic [OutW-1:0] sat_out(input logic [TimeBits-1:0] v);
    logic [31:0] w;
    w = 32'(v);
    sat_out = (w > 32'hFFFF) ? {OutW{1'b1}} : OutW'(w);
  endfunction

endpackage

[sv/srtf_front.sv]
// request decode and two-entry queue ahead of the scheduler core
module srtf_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    req_type_i,
  input  logic [srtf_pkg::IdW-1:0]      proc_id_i,
  input  logic [15:0]                   arrive_at_i,
  input  logic [15:0]                   burst_len_i,
  output logic                          q_valid_o,
  output srtf_pkg::req_t                q_req_o,
  input  logic                          q_pop_i
);

  srtf_pkg::req_t mem_q [2];
  logic           wr_ptr_q, rd_ptr_q;
  logic [1:0]     cnt_q;
  srtf_pkg::req_t dec;
  logic           push;

  always_comb begin
    dec.id       = proc_id_i;
    dec.arr      = srtf_pkg::clamp_time(arrive_at_i);
    dec.burst    = burst_len_i;
    dec.burst_nz = (burst_len_i != '0);
    case (req_type_i)
      srtf_pkg::ReqLoad:  dec.op = srtf_pkg::OP_LOAD;
      srtf_pkg::ReqTick:  dec.op = srtf_pkg::OP_TICK;
      srtf_pkg::ReqClear: dec.op = srtf_pkg::OP_CLEAR;
      default:            dec.op = srtf_pkg::OP_NOP;
    endcase
  end

  assign in_stall_o = (cnt_q == 2'd2);
  assign push       = in_valid_i && !in_stall_o;
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_req_o    = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= dec;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= !wr_ptr_q;
      if (q_pop_i) rd_ptr_q <= !rd_ptr_q;
      cnt_q <= cnt_q + 2'(push) - 2'(q_pop_i);
    end
  end

endmodule

[sv/srtf_back.sv]
// process table, serial minimum scan and result register
module srtf_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_valid_i,
  input  srtf_pkg::req_t     q_req_i,
  output logic               q_pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output srtf_pkg::rsp_t     rsp_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EXEC
  } state_e;

  localparam int TB = srtf_pkg::TimeBits;
  localparam int IW = srtf_pkg::IdxW;
  localparam int CW = srtf_pkg::CntW;

  logic [srtf_pkg::IdW-1:0]  id_mem   [srtf_pkg::MaxProcs];
  logic [TB-1:0]             arr_mem  [srtf_pkg::MaxProcs];
  logic [srtf_pkg::OutW-1:0] bst_mem  [srtf_pkg::MaxProcs];
  logic [srtf_pkg::OutW-1:0] left_mem [srtf_pkg::MaxProcs];

  state_e                    state_q;
  srtf_pkg::req_t            req_q;
  logic [CW-1:0]             cnt_q, done_q, scan_q;
  logic [TB-1:0]             time_q;
  logic [srtf_pkg::IdW:0]    last_q;
  logic                      rd_vld_q;
  logic [IW-1:0]             rd_idx_q;
  logic [srtf_pkg::IdW-1:0]  rd_id_q;
  logic [TB-1:0]             rd_arr_q;
  logic [srtf_pkg::OutW-1:0] rd_bst_q, rd_left_q;
  logic                      found_q;
  logic [IW-1:0]             best_idx_q;
  logic [srtf_pkg::IdW-1:0]  best_id_q;
  logic [TB-1:0]             best_arr_q;
  logic [srtf_pkg::OutW-1:0] best_bst_q, best_left_q;
  logic                      out_valid_q;
  srtf_pkg::rsp_t            rsp_q;

  logic                      cand, better, out_free, do_exec;
  logic                      ld_ok, fin;
  logic [TB-1:0]             time_d;
  logic [srtf_pkg::OutW-1:0] left_d;
  logic [TB-1:0]             turn, wait_t;
  logic [CW-1:0]             cnt_d, done_d;
  srtf_pkg::rsp_t            rsp_d;

  assign out_valid_o = out_valid_q;
  assign rsp_o       = rsp_q;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign q_pop_o     = (state_q == ST_IDLE) && q_valid_i;
  assign do_exec     = (state_q == ST_EXEC) && out_free;

  assign cand   = rd_vld_q && (rd_arr_q <= time_q) && (rd_left_q != '0);
  assign better = !found_q || (rd_left_q < best_left_q) ||
                  (rd_left_q == best_left_q && rd_arr_q < best_arr_q) ||
                  (rd_left_q == best_left_q && rd_arr_q == best_arr_q &&
                   rd_id_q < best_id_q);

  always_comb begin
    time_d = (time_q != srtf_pkg::TimeMax) ? time_q + TB'(1) : time_q;
    left_d = best_left_q - srtf_pkg::OutW'(1);
    fin    = found_q && (left_d == '0);
    turn   = time_d - best_arr_q;
    wait_t = (32'(turn) >= 32'(best_bst_q)) ? TB'(32'(turn) - 32'(best_bst_q)) : '0;
    ld_ok  = (32'(cnt_q) < 32'(srtf_pkg::MaxProcs)) && req_q.burst_nz;
    cnt_d  = cnt_q;
    done_d = done_q;
    rsp_d  = '0;
    case (req_q.op)
      srtf_pkg::OP_LOAD: begin
        rsp_d.accepted = ld_ok;
        if (ld_ok) cnt_d = cnt_q + CW'(1);
      end
      srtf_pkg::OP_TICK: begin
        rsp_d.idle = !found_q;
        if (found_q) begin
          rsp_d.run_id   = best_id_q;
          rsp_d.switched = (last_q != {1'b0, best_id_q});
          rsp_d.finished = fin;
          if (fin) begin
            rsp_d.turnaround = srtf_pkg::sat_out(turn);
            rsp_d.waiting    = srtf_pkg::sat_out(wait_t);
            done_d           = done_q + CW'(1);
          end
        end
      end
      srtf_pkg::OP_CLEAR: begin
        cnt_d  = '0;
        done_d = '0;
      end
      default: begin
      end
    endcase
    rsp_d.all_done = (done_d == cnt_d);
    case (req_q.op)
      srtf_pkg::OP_TICK:  rsp_d.now = srtf_pkg::sat_out(time_d);
      srtf_pkg::OP_CLEAR: rsp_d.now = '0;
      default:            rsp_d.now = srtf_pkg::sat_out(time_q);
    endcase
  end

  always_ff @(posedge clk_i) begin
    rd_id_q   <= id_mem[scan_q[IW-1:0]];
    rd_arr_q  <= arr_mem[scan_q[IW-1:0]];
    rd_bst_q  <= bst_mem[scan_q[IW-1:0]];
    rd_left_q <= left_mem[scan_q[IW-1:0]];
    rd_idx_q  <= scan_q[IW-1:0];
    if (do_exec && req_q.op == srtf_pkg::OP_LOAD && ld_ok) begin
      id_mem[cnt_q[IW-1:0]]   <= req_q.id;
      arr_mem[cnt_q[IW-1:0]]  <= req_q.arr;
      bst_mem[cnt_q[IW-1:0]]  <= req_q.burst;
      left_mem[cnt_q[IW-1:0]] <= req_q.burst;
    end else if (do_exec && req_q.op == srtf_pkg::OP_TICK && found_q) begin
      left_mem[best_idx_q] <= left_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      req_q       <= '0;
      cnt_q       <= '0;
      done_q      <= '0;
      scan_q      <= '0;
      time_q      <= '0;
      last_q      <= {1'b1, {srtf_pkg::IdW{1'b0}}};
      rd_vld_q    <= 1'b0;
      found_q     <= 1'b0;
      best_idx_q  <= '0;
      best_id_q   <= '0;
      best_arr_q  <= '0;
      best_bst_q  <= '0;
      best_left_q <= '0;
      out_valid_q <= 1'b0;
      rsp_q       <= '0;
    end else begin
      if (out_valid_q && !out_stall_i && !do_exec) out_valid_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (q_valid_i) begin
            req_q    <= q_req_i;
            scan_q   <= '0;
            rd_vld_q <= 1'b0;
            found_q  <= 1'b0;
            state_q  <= (q_req_i.op == srtf_pkg::OP_TICK) ? ST_SCAN : ST_EXEC;
          end
        end
        ST_SCAN: begin
          rd_vld_q <= (scan_q < cnt_q);
          if (scan_q < cnt_q) scan_q <= scan_q + CW'(1);
          if (cand && better) begin
            found_q     <= 1'b1;
            best_idx_q  <= rd_idx_q;
            best_id_q   <= rd_id_q;
            best_arr_q  <= rd_arr_q;
            best_bst_q  <= rd_bst_q;
            best_left_q <= rd_left_q;
          end
          if (!(scan_q < cnt_q) && !rd_vld_q) state_q <= ST_EXEC;
        end
        ST_EXEC: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            rsp_q       <= rsp_d;
            cnt_q       <= cnt_d;
            done_q      <= done_d;
            state_q     <= ST_IDLE;
            case (req_q.op)
              srtf_pkg::OP_TICK: begin
                time_q <= time_d;
                last_q <= found_q ? {1'b0, best_id_q} : {1'b1, {srtf_pkg::IdW{1'b0}}};
              end
              srtf_pkg::OP_CLEAR: begin
                time_q <= '0;
                last_q <= {1'b1, {srtf_pkg::IdW{1'b0}}};
              end
              default: begin
              end
            endcase
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

[sv/srtf_tick_scheduler_unit.sv]
// top level of the shortest-remaining-time tick scheduler
//  channel | direction | handshake              | beat fields
//  in      | input     | in_valid_i/in_stall_o   | req_type, proc_id, arrive_at, burst_len
//  out     | output    | out_valid_o/out_stall_i | accepted .. now
// a tick passes through the scan state, where the table memory is read
// one entry a cycle, and then through the execute state
// load, clear and other beats go from idle straight to the execute state
// a two-beat queue takes input while the core works; the result register lets
// the core take and scan the next beat when the output side stalls
// reset empties the table at once through the fill count; no clearing pass
module srtf_tick_scheduler_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  req_type_i,
  input  logic [7:0]  proc_id_i,
  input  logic [15:0] arrive_at_i,
  input  logic [15:0] burst_len_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        accepted_o,
  output logic        idle_o,
  output logic [7:0]  run_id_o,
  output logic        switched_o,
  output logic        finished_o,
  output logic [15:0] turnaround_o,
  output logic [15:0] waiting_o,
  output logic        all_done_o,
  output logic [15:0] now_o
);

  logic           q_valid, q_pop;
  srtf_pkg::req_t q_req;
  srtf_pkg::rsp_t rsp;

  srtf_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o,
    .req_type_i, .proc_id_i, .arrive_at_i, .burst_len_i,
    .q_valid_o(q_valid), .q_req_o(q_req), .q_pop_i(q_pop)
  );

  srtf_back u_back (
    .clk_i, .rst_ni,
    .q_valid_i(q_valid), .q_req_i(q_req), .q_pop_o(q_pop),
    .out_valid_o, .out_stall_i, .rsp_o(rsp)
  );

  assign accepted_o   = rsp.accepted;
  assign idle_o       = rsp.idle;
  assign run_id_o     = rsp.run_id;
  assign switched_o   = rsp.switched;
  assign finished_o   = rsp.finished;
  assign turnaround_o = rsp.turnaround;
  assign waiting_o    = rsp.waiting;
  assign all_done_o   = rsp.all_done;
  assign now_o        = rsp.now;

endmodule

[sv/srtf_checker.sv]
// port-level checks for the scheduler, bound to the top level
module srtf_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic        accepted_o,
  input logic        idle_o,
  input logic        switched_o,
  input logic        finished_o,
  input logic [15:0] turnaround_o,
  input logic [15:0] now_o
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(now_o))
    else $error("stalled result beat changed");

  a_idle_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && idle_o |-> !finished_o && !switched_o && !accepted_o)
    else $error("idle tick reports a run");

  a_accept_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && accepted_o |-> !finished_o && !idle_o)
    else $error("load beat reports tick fields");

  a_turn: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && finished_o |-> turnaround_o != 16'd0 && now_o != 16'd0)
    else $error("finish with zero turnaround");

endmodule

bind srtf_tick_scheduler_unit srtf_checker u_srtf_checker (
  .clk_i, .rst_ni, .out_valid_o, .out_stall_i, .accepted_o, .idle_o,
  .switched_o, .finished_o, .turnaround_o, .now_o
);
